// ----- design/tbfe_pkg.sv -----
// Package with shared types and constants for the byte frame engine.
package tbfe_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DELAY_W = 16;

  localparam logic [0:0] REG_HALF_BIT_DELAY = 1'b0;
  localparam logic [DELAY_W-1:0] HALF_BIT_DELAY_RESET = 16'd10;

  localparam int unsigned DEF_START_SEARCH_BITS = 192;
  localparam int unsigned DEF_BREAK_BITS = 26;
  localparam int unsigned DEF_RESET_IDLE_BITS = 32;

  localparam logic [7:0] DATA_BITS = 8'd8;
  localparam logic [7:0] PARITY_BIT_POS = 8'd9;
  localparam logic [7:0] SEND_FRAME_BITS = 8'd12;
  localparam logic [7:0] STOP_BITS = 8'd2;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_RESET = 2'd1,
    MODE_SEND = 2'd2,
    MODE_RECV = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_NO_START = 2'd1,
    STATUS_PARITY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    STEP_IDLE = 3'd0,
    STEP_RESET = 3'd1,
    STEP_SEND = 3'd2,
    STEP_SEARCH = 3'd3,
    STEP_RECV = 3'd4,
    STEP_BREAK = 3'd5,
    STEP_STOP = 3'd6
  } step_t;

  typedef struct packed {
    logic       clock_level;
    logic       data_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] rx_status;
  } res_t;

endpackage

// ----- design/tbfe_cfg.sv -----
// Configuration register file with its APB-style access port.
module tbfe_cfg
  import tbfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DELAY_W-1:0]    half_bit_delay
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_delay <= HALF_BIT_DELAY_RESET;
    end else if (wr_en && (paddr[2] == REG_HALF_BIT_DELAY)) begin
      half_bit_delay <= pwdata[DELAY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_HALF_BIT_DELAY: prdata = {{(CFG_DATA_W-DELAY_W){1'b0}}, half_bit_delay};
      default:            prdata = '0;
    endcase
  end

endmodule

// ----- design/tbfe_seq.sv -----
// Prescaler and bit sequencer that advance by one system tick per item.
module tbfe_seq
  import tbfe_pkg::*;
#(
  parameter int unsigned START_SEARCH_BITS = DEF_START_SEARCH_BITS,
  parameter int unsigned BREAK_BITS = DEF_BREAK_BITS,
  parameter int unsigned RESET_IDLE_BITS = DEF_RESET_IDLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  logic [1:0]         mode,
  input  logic [7:0]         tx_byte,
  input  logic               line_in,
  input  logic [DELAY_W-1:0] half_bit_delay,
  output res_t               res_next
);

  localparam logic [7:0] SEARCH_LIMIT = 8'(START_SEARCH_BITS);
  localparam logic [7:0] BREAK_LIMIT = 8'(BREAK_BITS);
  localparam logic [7:0] IDLE_LIMIT = 8'(RESET_IDLE_BITS);

  logic [DELAY_W-1:0] prescale_count, prescale_count_next;
  logic               clock_phase, clock_phase_next;
  step_t              step, step_next;
  logic [7:0]         bit_count, bit_count_next;
  logic [7:0]         shift_reg, shift_reg_next;
  logic               parity_acc, parity_acc_next;
  logic [7:0]         last_rx_byte, last_rx_byte_next;
  logic [1:0]         last_status, last_status_next;
  logic               sample_bit, sample_bit_next;
  logic               drive_bit, drive_bit_next;
  logic               done;

  always_comb begin
    logic [7:0] bc1;
    logic       fin;
    logic       par;
    prescale_count_next = prescale_count;
    clock_phase_next = clock_phase;
    step_next = step;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    parity_acc_next = parity_acc;
    last_rx_byte_next = last_rx_byte;
    last_status_next = last_status;
    sample_bit_next = sample_bit;
    drive_bit_next = drive_bit;
    done = 1'b0;
    fin = 1'b0;
    bc1 = bit_count + 8'd1;
    par = parity_acc ^ sample_bit;

    if (step == STEP_IDLE || step > STEP_STOP) begin
      step_next = STEP_IDLE;
      clock_phase_next = 1'b0;
      drive_bit_next = 1'b1;
      if (mode != MODE_TICK) begin
        prescale_count_next = '0;
        bit_count_next = '0;
        unique case (mode)
          MODE_RESET: step_next = STEP_RESET;
          MODE_SEND: begin
            step_next = STEP_SEND;
            shift_reg_next = tx_byte;
            parity_acc_next = ^tx_byte;
            drive_bit_next = 1'b0;
          end
          default: step_next = STEP_SEARCH;
        endcase
      end
    end else if (prescale_count >= half_bit_delay) begin
      prescale_count_next = '0;
      if (!clock_phase) begin
        clock_phase_next = 1'b1;
        sample_bit_next = line_in;
      end else begin
        clock_phase_next = 1'b0;
        unique case (step)
          STEP_RESET: begin
            bit_count_next = bc1;
            if (bc1 >= IDLE_LIMIT) fin = 1'b1;
            else drive_bit_next = 1'b1;
          end
          STEP_SEND: begin
            bit_count_next = bc1;
            if (bc1 >= SEND_FRAME_BITS) fin = 1'b1;
            else if (bc1 <= DATA_BITS) drive_bit_next = shift_reg[3'(bc1 - 8'd1)];
            else if (bc1 == PARITY_BIT_POS) drive_bit_next = parity_acc;
            else drive_bit_next = 1'b1;
          end
          STEP_SEARCH: begin
            if (!sample_bit) begin
              step_next = STEP_RECV;
              bit_count_next = '0;
              shift_reg_next = '0;
              parity_acc_next = 1'b0;
              drive_bit_next = 1'b1;
            end else begin
              bit_count_next = bc1;
              if (bc1 >= SEARCH_LIMIT) begin
                last_status_next = STATUS_NO_START;
                last_rx_byte_next = '0;
                step_next = STEP_BREAK;
                bit_count_next = '0;
                drive_bit_next = 1'b0;
              end else begin
                drive_bit_next = 1'b1;
              end
            end
          end
          STEP_RECV: begin
            parity_acc_next = par;
            if (bit_count < DATA_BITS) begin
              shift_reg_next = {sample_bit, shift_reg[7:1]};
              bit_count_next = bc1;
              drive_bit_next = 1'b1;
            end else if (par) begin
              last_status_next = STATUS_PARITY;
              last_rx_byte_next = '0;
              step_next = STEP_BREAK;
              bit_count_next = '0;
              drive_bit_next = 1'b0;
            end else begin
              last_rx_byte_next = shift_reg;
              last_status_next = STATUS_OK;
              step_next = STEP_STOP;
              bit_count_next = '0;
              drive_bit_next = 1'b1;
            end
          end
          STEP_BREAK: begin
            bit_count_next = bc1;
            if (bc1 > BREAK_LIMIT) fin = 1'b1;
            else drive_bit_next = (bc1 == BREAK_LIMIT);
          end
          STEP_STOP: begin
            bit_count_next = bc1;
            if (bc1 >= STOP_BITS) fin = 1'b1;
            else drive_bit_next = 1'b1;
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          step_next = STEP_IDLE;
          bit_count_next = '0;
          drive_bit_next = 1'b1;
          done = 1'b1;
        end
      end
    end else begin
      prescale_count_next = prescale_count + DELAY_W'(1);
    end
  end

  always_comb begin
    res_next.clock_level = clock_phase_next;
    res_next.data_level = drive_bit_next;
    res_next.busy_res = (step_next != STEP_IDLE);
    res_next.done_res = done;
    res_next.rx_byte = last_rx_byte_next;
    res_next.rx_status = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      clock_phase <= 1'b0;
      step <= STEP_IDLE;
      bit_count <= '0;
      shift_reg <= '0;
      parity_acc <= 1'b0;
      last_rx_byte <= '0;
      last_status <= STATUS_OK;
      sample_bit <= 1'b0;
      drive_bit <= 1'b1;
    end else if (step_en) begin
      prescale_count <= prescale_count_next;
      clock_phase <= clock_phase_next;
      step <= step_next;
      bit_count <= bit_count_next;
      shift_reg <= shift_reg_next;
      parity_acc <= parity_acc_next;
      last_rx_byte <= last_rx_byte_next;
      last_status <= last_status_next;
      sample_bit <= sample_bit_next;
      drive_bit <= drive_bit_next;
    end
  end

endmodule

// ----- design/tpi_byte_frame_engine_core.sv -----
// Top level of the byte frame engine: tick input register, sequencer and result register.
//
// Each input transaction on the item channel (item_valid, item_stall) is one
// system tick of the link master, with an optional command in mode and the
// byte to send in tx_byte. Each tick yields exactly one result transaction
// on the res channel (res_valid, res_stall) carrying the clock and data pin
// levels, busy and done flags and the latest receive byte and status.
// A tick is held in an input register, then the sequencer updates its state
// and the result lands in an output register once that register is free to
// take it. One tick is taken every cycle while the result side keeps
// up; when res_stall is high the result register holds its transaction
// and item_stall rises as soon as the input register is also occupied.
// The link speed is set through the APB port by half_bit_delay at
// address zero. Reset empties both registers, sets half_bit_delay to 10
// and returns the sequencer to idle with the clock low and the data line
// released.
module tpi_byte_frame_engine_core
  import tbfe_pkg::*;
#(
  parameter int unsigned START_SEARCH_BITS = DEF_START_SEARCH_BITS,
  parameter int unsigned BREAK_BITS = DEF_BREAK_BITS,
  parameter int unsigned RESET_IDLE_BITS = DEF_RESET_IDLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            mode,
  input  logic [7:0]            tx_byte,
  input  logic                  line_in,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  clock_level,
  output logic                  data_level,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [7:0]            rx_byte,
  output logic [1:0]            rx_status
);

  logic [DELAY_W-1:0] half_bit_delay;
  logic               in_full;
  logic [1:0]         mode_q;
  logic [7:0]         tx_byte_q;
  logic               line_in_q;
  logic               res_free;
  logic               advance;
  logic               item_take;
  res_t               res_next;
  res_t               res_q;

  tbfe_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .half_bit_delay (half_bit_delay)
  );

  assign res_free = !res_valid || !res_stall;
  assign advance = in_full && res_free;
  assign item_stall = in_full && !res_free;
  assign item_take = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      mode_q <= mode;
      tx_byte_q <= tx_byte;
      line_in_q <= line_in;
    end
  end

  tbfe_seq #(
    .START_SEARCH_BITS (START_SEARCH_BITS),
    .BREAK_BITS        (BREAK_BITS),
    .RESET_IDLE_BITS   (RESET_IDLE_BITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .step_en        (advance),
    .mode           (mode_q),
    .tx_byte        (tx_byte_q),
    .line_in        (line_in_q),
    .half_bit_delay (half_bit_delay),
    .res_next       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign clock_level = res_q.clock_level;
  assign data_level = res_q.data_level;
  assign busy_res = res_q.busy_res;
  assign done_res = res_q.done_res;
  assign rx_byte = res_q.rx_byte;
  assign rx_status = res_q.rx_status;

endmodule
